[rtl/bdq_pkg.sv]
// Shared types and constants for the bounded double-ended queue.
package bdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int OPCODE_W       = 3;
  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 5;

  localparam logic [OPCODE_W-1:0] OP_NOP        = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd5;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  push_value;
  } cmd_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] back_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               is_full;
    logic               push_rejected;
  } res_item_t;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic clear;
    logic head_in;
    logic head_out;
    logic tail_in;
    logic tail_out;
  } cell_op_t;

endpackage

[rtl/bdq_cell.sv]
// One storage cell of the deque row: a data word, its valid bit and the neighbour moves.
module bdq_cell #(
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bdq_pkg::cell_op_t     op,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic                  prev_valid,
  input  logic [DATA_WIDTH-1:0] next_data,
  input  logic                  next_valid,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid,
  output logic                  last
);
  import bdq_pkg::*;

  logic [DATA_WIDTH-1:0] data_next;
  logic                  valid_next;

  // Occupied cells always form an unbroken run from the front cell, so the
  // back end is found locally by looking at the neighbour only.
  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (op.clear) begin
      valid_next = 1'b0;
    end else if (op.head_in) begin
      data_next  = prev_data;
      valid_next = prev_valid;
    end else if (op.head_out) begin
      data_next  = next_data;
      valid_next = next_valid;
    end else if (op.tail_in && !valid && prev_valid) begin
      data_next  = word;
      valid_next = 1'b1;
    end else if (op.tail_out && valid && !next_valid) begin
      valid_next = 1'b0;
    end
  end

  assign last = valid && !next_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[rtl/bdq_ctrl.sv]
// Handshake, opcode decode, word count and result register of the deque.
module bdq_ctrl #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [bdq_pkg::OPCODE_W-1:0]  opcode,
  output bdq_pkg::cell_op_t             op,
  input  logic [bdq_pkg::VALUE_W-1:0]   front_word,
  input  logic [bdq_pkg::VALUE_W-1:0]   back_word,
  output logic                          res_valid,
  input  logic                          res_stall,
  output bdq_pkg::res_item_t            res
);
  import bdq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pending;
  logic             rejected;
  logic             rejected_next;
  logic             load;
  logic             accept;
  logic             full;
  logic             empty;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;

  // A result is taken from the cell row in the cycle after its item's
  // transfer, or later while stalled; a new item may enter in that cycle.
  assign load      = pending && (!res_valid || !res_stall);
  assign cmd_stall = pending && !load;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    op            = '0;
    count_next    = count;
    rejected_next = 1'b0;
    if (accept) begin
      case (opcode)
        OP_NOP: begin
        end
        OP_PUSH_BACK: begin
          if (full) begin
            rejected_next = 1'b1;
          end else begin
            op.tail_in = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            rejected_next = 1'b1;
          end else begin
            op.head_in = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (!empty) begin
            op.tail_out = 1'b1;
            count_next  = count - CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            op.head_out = 1'b1;
            count_next  = count - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          op.clear   = 1'b1;
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pending   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        pending <= 1'b1;
      end else if (load) begin
        pending <= 1'b0;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rejected <= rejected_next;
    end
    if (load) begin
      res.front_value   <= front_word;
      res.back_value    <= back_word;
      res.entry_count   <= COUNT_W'(count);
      res.is_empty      <= empty;
      res.is_full       <= full;
      res.push_rejected <= rejected;
    end
  end

endmodule

[rtl/bounded_deque.sv]
// Bounded double-ended queue: top level with the cell row and control.
//
// Items arrive on the cmd channel (cmd_valid, cmd_stall, cmd) and carry an
// opcode: no-op, push back, push front, pop back, pop front or clear. Every
// item yields exactly one result on the res channel (res_valid, res_stall,
// res) with the front and back words, the word count and the empty, full
// and push-rejected flags as they stand after that item.
// Words live in a row of DEPTH cells with the front word in cell zero; a
// push or pop at the front shifts the whole row by one cell.
// The result is shown once the result register has loaded from the
// updated row. Throughput: one item per cycle while the receiver keeps
// taking results.
// A push into a full queue is dropped and flagged; a pop on an empty queue
// leaves it as it is. While res_stall holds a result, at most one further
// item is taken and then cmd_stall rises until the result register frees.
// Reset empties the row at once and drops any result not yet transferred.
module bounded_deque #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  bdq_pkg::cmd_item_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output bdq_pkg::res_item_t res
);
  import bdq_pkg::*;

  localparam int CW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

  cell_op_t              op;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      valid_vec;
  logic [DEPTH-1:0]      last_vec;
  logic [DATA_WIDTH-1:0] front_sel;
  logic [DATA_WIDTH-1:0] back_sel;
  logic [VALUE_W-1:0]    front_word;
  logic [VALUE_W-1:0]    back_word;

  assign word = DATA_WIDTH'(cmd.push_value[CW-1:0]);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data;
    logic                  prev_valid;
    logic [DATA_WIDTH-1:0] next_data;
    logic                  next_valid;

    // The front cell sees the incoming word as its left neighbour, and the
    // last cell sees an empty neighbour beyond the end of the row.
    if (i == 0) begin : g_head
      assign prev_data  = word;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_data  = cell_data[i-1];
      assign prev_valid = valid_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_data  = cell_data[i+1];
      assign next_valid = valid_vec[i+1];
    end

    bdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .word      (word),
      .prev_data (prev_data),
      .prev_valid(prev_valid),
      .next_data (next_data),
      .next_valid(next_valid),
      .data      (cell_data[i]),
      .valid     (valid_vec[i]),
      .last      (last_vec[i])
    );
  end

  // Exactly one cell is marked last when the queue holds words, none when empty.
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_sel = back_sel | (cell_data[i] & {DATA_WIDTH{last_vec[i]}});
    end
  end

  assign front_sel  = cell_data[0] & {DATA_WIDTH{valid_vec[0]}};
  assign front_word = VALUE_W'(front_sel[CW-1:0]);
  assign back_word  = VALUE_W'(back_sel[CW-1:0]);

  bdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .opcode    (cmd.opcode),
    .op        (op),
    .front_word(front_word),
    .back_word (back_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef SYNTHESIS
  a_valid_run : assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("occupied cells do not form one run from the front");

  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_empty |-> res.front_value == '0 && res.back_value == '0)
    else $error("empty result carries a non-zero word");

  a_reject_full : assert property (@(posedge clk) disable iff (rst)
    res_valid && res.push_rejected |-> res.is_full && !res.is_empty)
    else $error("push rejected while the queue was not full");
`endif

endmodule

[tb/deque_checker.sv]
// Checker for the bounded deque: predicts every result from the accepted commands and compares.
`timescale 1ns / 100ps

module deque_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  bdq_pkg::cmd_item_t cmd,
  input  logic               res_valid,
  input  logic               res_stall,
  input  bdq_pkg::res_item_t res,
  output int                 fail_count,
  output int                 pending,
  output int                 checked,
  output int                 full_hits,
  output int                 reject_hits
);
  import bdq_pkg::*;

  localparam int SLOTS = DEPTH_DEF;
  localparam int IDX_W = $clog2(SLOTS);

  // Circular model of the deque contents; tail_idx points one past the back word.
  logic [VALUE_W-1:0] slot_words [SLOTS];
  logic [IDX_W-1:0]   head_idx = '0;
  logic [IDX_W-1:0]   tail_idx = '0;
  logic [COUNT_W-1:0] word_count = '0;

  res_item_t expected_q[$];

  int fails = 0;
  int pending_n = 0;
  int checked_n = 0;
  int full_n = 0;
  int reject_n = 0;

  assign fail_count  = fails;
  assign pending     = pending_n;
  assign checked     = checked_n;
  assign full_hits   = full_n;
  assign reject_hits = reject_n;

  function automatic res_item_t deque_step(cmd_item_t c);
    res_item_t        r;
    logic             at_capacity;
    logic [IDX_W-1:0] back_idx;
    r = '0;
    at_capacity = (word_count >= SLOTS);
    case (c.opcode)
      OP_PUSH_BACK: begin
        if (at_capacity) begin
          r.push_rejected = 1'b1;
        end else begin
          slot_words[tail_idx] = c.push_value;
          tail_idx = tail_idx + 1'b1;
          word_count = word_count + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (at_capacity) begin
          r.push_rejected = 1'b1;
        end else begin
          head_idx = head_idx - 1'b1;
          slot_words[head_idx] = c.push_value;
          word_count = word_count + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (word_count != 0) begin
          tail_idx = tail_idx - 1'b1;
          word_count = word_count - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (word_count != 0) begin
          head_idx = head_idx + 1'b1;
          word_count = word_count - 1'b1;
        end
      end
      OP_CLEAR: begin
        head_idx = '0;
        tail_idx = '0;
        word_count = '0;
      end
      default: begin
      end
    endcase
    back_idx = tail_idx - 1'b1;
    if (word_count != 0) begin
      r.front_value = slot_words[head_idx];
      r.back_value  = slot_words[back_idx];
    end
    r.entry_count = word_count;
    r.is_empty    = (word_count == 0);
    r.is_full     = (word_count >= SLOTS);
    return r;
  endfunction

  function automatic void check_field(string field, logic [VALUE_W-1:0] want,
                                      logic [VALUE_W-1:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      head_idx = '0;
      tail_idx = '0;
      word_count = '0;
      expected_q.delete();
    end else begin
      // A result can never leave in the cycle its command transfers, so check first.
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: result with none expected, expected nothing, actual %p", $time, res);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          check_field("front_value", want.front_value, res.front_value);
          check_field("back_value", want.back_value, res.back_value);
          check_field("entry_count", want.entry_count, res.entry_count);
          check_field("is_empty", want.is_empty, res.is_empty);
          check_field("is_full", want.is_full, res.is_full);
          check_field("push_rejected", want.push_rejected, res.push_rejected);
          checked_n++;
        end
      end
      if (cmd_valid && !cmd_stall) begin
        want = deque_step(cmd);
        expected_q = {expected_q, want};
        if (want.is_full) full_n++;
        if (want.push_rejected) reject_n++;
      end
    end
    pending_n = expected_q.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the bounded deque testbench: clock, reset, command stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
  import bdq_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_ITEMS   = 80;
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  cmd_item_t cmd = '0;
  logic      res_stall = 1'b0;
  logic      cmd_stall;
  logic      res_valid;
  res_item_t res;

  bit idle_on = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int fail_count, pending, checked, full_hits, reject_hits;

  bounded_deque dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  deque_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .full_hits   (full_hits),
    .reject_hits (reject_hits)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding", pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stalls arrive in bursts of random length while idling is enabled.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      res_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      res_stall <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      res_stall <= 1'b0;
    end
  end

  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Holds the command until it transfers, then sometimes leaves a gap.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] word);
    cmd_valid <= 1'b1;
    cmd <= '{opcode: op, push_value: word};
    do @(posedge clk); while (cmd_stall);
    items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    int                  effective;
    int                  burst;
    int                  push_pct;
    int                  pick;
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0]  word;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pops on an empty queue, the no-op codes, a fill to capacity
    // from both ends, rejected pushes at both ends, pops and a clear.
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '1);
    send_item(OP_NOP, 32'h1234_5678);
    send_item(OP_SPARE_6, '0);
    send_item(OP_SPARE_7, '1);
    for (int i = 0; i < DEPTH_DEF; i++) begin
      word = (i == 0) ? '0 : (i == 1) ? '1 : (i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA) ^ i;
      send_item(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, word);
    end
    send_item(OP_PUSH_BACK, 32'hDEAD_0001);
    send_item(OP_PUSH_FRONT, 32'hDEAD_0002);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_CLEAR, '1);

    // Random: episodes that lean towards filling, draining or neither, so
    // both the full and the empty boundaries are crossed many times.
    effective = 0;
    while (effective < RANDOM_ITEMS) begin
      burst = $urandom_range(20, 40);
      case ($urandom_range(0, 2))
        0: push_pct = 80;
        1: push_pct = 25;
        default: push_pct = 50;
      endcase
      idle_on = (effective < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 9) < 7);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
          op = OP_CLEAR;
        end else if (pick < 4) begin
          case ($urandom_range(0, 2))
            0: op = OP_NOP;
            1: op = OP_SPARE_6;
            default: op = OP_SPARE_7;
          endcase
        end else if (pick < 4 + push_pct * 96 / 100) begin
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        end
        if (op != OP_NOP && op != OP_SPARE_6 && op != OP_SPARE_7) effective++;
        send_item(op, random_word());
      end
    end
    cmd_valid <= 1'b0;
    idle_on = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d commands across all six operations and the spare codes;", items_sent);
    $display("checked %0d results, queue full %0d times, %0d pushes rejected.",
             checked, full_hits, reject_hits);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque.sv
tb/deque_checker.sv
tb/tb_top.sv
